/* rtl/lzss_ring_decompressor_defines.svh */
// Assertion macros for the LZSS decoder.
// Each macro checks a property on the rising edge of aclk, gated off during reset.
`ifndef LZSS_RING_DECOMPRESSOR_DEFINES_SVH
`define LZSS_RING_DECOMPRESSOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LZRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lzrd assertion failed");
// next-cycle implication
`define LZRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lzrd assertion failed");
`else
`define LZRD_ASSERT_NOW(lbl, ante, cons)
`define LZRD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/lzrd_pkg.sv */
package lzrd_pkg;

    // history window geometry
    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    // stream format
    localparam logic [4:0]        HDR_BYTES  = 5'd16;
    localparam logic [4:0]        SIZE_FIRST = 5'd8;
    localparam logic [4:0]        SIZE_LAST  = 5'd11;
    localparam logic [WIN_AW-1:0] MATCH_BIAS = WIN_AW'(18);
    localparam logic [4:0]        MATCH_MIN  = 5'd3;
    localparam logic [3:0]        BITS_DONE  = 4'd8;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    // window port request
    typedef struct packed {
        logic              wr_en;
        logic [WIN_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
    } ram_req_t;

endpackage

/* rtl/lzrd_hist_ram.sv */
module lzrd_hist_ram
    import lzrd_pkg::*;
(
    input  logic       aclk,
    input  ram_req_t   req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [WIN_DEPTH];

    // one write and one registered read per cycle; read returns old data
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

/* rtl/lzss_ring_decompressor.sv */
// LZSS decoder with a 4096-byte history window.
// Input channel s_*: one compressed byte per word; s_tuser marks the first
// header byte of a new stream and clears all stream counters first.
// Output channel m_*: one decoded byte per word; m_tlast closes the bytes
// caused by one input word, m_tuser flags that the decoded size is reached.
// Header, control and first-match bytes give no output.
// A literal gives one word. The second match byte starts a copy of 3 to 18
// bytes, cut short when the decoded size is reached, one byte per cycle while
// the output slot is free, limited by the single write and single read port of
// the window memory; no new input is taken until the copy ends.
// Each decoded byte shows up on m_* in the cycle after the one that makes it.
// Later bytes of a copy at distance one forward the byte just written.
// The output register frees in the cycle its word is taken, so the next input
// word can enter in that same cycle; while a result waits, s_tready stays low.
// When m_tready is low, copying pauses with the window read held and resumes
// without loss. Reset clears counters to the start-of-stream state; the
// window is not cleared, only bytes written in the current stream are read.
`include "lzss_ring_decompressor_defines.svh"

module lzss_ring_decompressor
    import lzrd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] stream_byte
    input  logic       s_tuser,   // stream_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // stream_done
);

    state_t            state_reg, state_next;
    logic [31:0]       count_reg, count_next;
    logic [31:0]       total_reg, total_next;
    logic [4:0]        hdr_reg, hdr_next;
    logic [7:0]        ctrl_reg, ctrl_next;
    logic [3:0]        bitpos_reg, bitpos_next;
    logic [7:0]        low_reg, low_next;
    logic              half_reg, half_next;
    logic [WIN_AW-1:0] dist_reg, dist_next;
    logic [4:0]        rem_reg, rem_next;
    logic              fwd_reg, fwd_next;
    logic [7:0]        fwd_data_reg, fwd_data_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              m_tuser_reg, m_tuser_next;

    logic              slot_free, in_acc, clr;
    logic [31:0]       e_count, e_total, base_count, count_inc;
    logic [4:0]        e_hdr;
    logic [3:0]        e_bitpos;
    logic [7:0]        e_low;
    logic              e_half, done_flag, zero_src;
    logic [WIN_AW-1:0] m_pos, m_dist;
    logic [7:0]        copy_byte, ram_q;
    ram_req_t          ram_req;

    // handshake
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign in_acc    = s_tvalid && s_tready;
    assign clr       = in_acc && s_tuser;

    // stream state after an optional start-of-stream clear
    assign e_count  = clr ? '0 : count_reg;
    assign e_total  = clr ? '0 : total_reg;
    assign e_hdr    = clr ? '0 : hdr_reg;
    assign e_bitpos = clr ? BITS_DONE : bitpos_reg;
    assign e_low    = clr ? '0 : low_reg;
    assign e_half   = clr ? 1'b0 : half_reg;

    // output count after the byte emitted this cycle
    assign base_count = (state_reg == ST_COPY) ? count_reg : e_count;
    assign count_inc  = base_count + 32'd1;
    assign done_flag  = (count_inc >= e_total);

    // match geometry from the second match byte
    assign m_pos  = {s_tdata[7:4], e_low};
    assign m_dist = e_count[WIN_AW-1:0] - MATCH_BIAS - m_pos;

    // copy source: zero for distance zero or before stream start
    assign zero_src  = (dist_reg == '0) ||
                       ((count_reg[31:WIN_AW] == '0) && (count_reg[WIN_AW-1:0] < dist_reg));
    assign copy_byte = zero_src ? 8'd0 : (fwd_reg ? fwd_data_reg : ram_q);

    // decode and copy sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = e_count;
        total_next    = e_total;
        hdr_next      = e_hdr;
        ctrl_next     = clr ? '0 : ctrl_reg;
        bitpos_next   = e_bitpos;
        low_next      = e_low;
        half_next     = e_half;
        dist_next     = dist_reg;
        rem_next      = rem_reg;
        fwd_next      = fwd_reg;
        fwd_data_next = fwd_data_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        ram_req       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (e_hdr < HDR_BYTES) begin
                        if (e_hdr >= SIZE_FIRST && e_hdr <= SIZE_LAST) begin
                            total_next[{e_hdr[1:0], 3'b000} +: 8] = s_tdata;
                        end
                        hdr_next = e_hdr + 5'd1;
                    end else if (e_count >= e_total) begin
                        // size reached: byte ignored
                    end else if (e_half) begin
                        half_next       = 1'b0;
                        bitpos_next     = e_bitpos + 4'd1;
                        dist_next       = m_dist;
                        rem_next        = MATCH_MIN + {1'b0, s_tdata[3:0]};
                        fwd_next        = 1'b0;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = e_count[WIN_AW-1:0] - m_dist;
                        state_next      = ST_COPY;
                    end else if (e_bitpos >= BITS_DONE) begin
                        ctrl_next   = s_tdata;
                        bitpos_next = '0;
                    end else if (ctrl_reg[e_bitpos[2:0]]) begin
                        bitpos_next     = e_bitpos + 4'd1;
                        count_next      = count_inc;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = e_count[WIN_AW-1:0];
                        ram_req.wr_data = s_tdata;
                        m_tvalid_next   = 1'b1;
                        m_tdata_next    = s_tdata;
                        m_tlast_next    = 1'b1;
                        m_tuser_next    = done_flag;
                    end else begin
                        low_next  = s_tdata;
                        half_next = 1'b1;
                    end
                end
            end
            ST_COPY: begin
                if (slot_free) begin
                    count_next      = count_inc;
                    rem_next        = rem_reg - 5'd1;
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = count_reg[WIN_AW-1:0];
                    ram_req.wr_data = copy_byte;
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = copy_byte;
                    m_tlast_next    = (rem_reg == 5'd1) || done_flag;
                    m_tuser_next    = done_flag;
                    if ((rem_reg == 5'd1) || done_flag) begin
                        state_next = ST_IDLE;
                    end else begin
                        // next source; forward when it is the entry written now
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = count_inc[WIN_AW-1:0] - dist_reg;
                        fwd_next        = (dist_reg == WIN_AW'(1));
                        fwd_data_next   = copy_byte;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            hdr_reg      <= '0;
            ctrl_reg     <= '0;
            bitpos_reg   <= BITS_DONE;
            low_reg      <= '0;
            half_reg     <= 1'b0;
            rem_reg      <= '0;
            fwd_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            hdr_reg      <= hdr_next;
            ctrl_reg     <= ctrl_next;
            bitpos_reg   <= bitpos_next;
            low_reg      <= low_next;
            half_reg     <= half_next;
            rem_reg      <= rem_next;
            fwd_reg      <= fwd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dist_reg     <= dist_next;
        fwd_data_reg <= fwd_data_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // history window
    lzrd_hist_ram u_hist_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `LZRD_ASSERT_NOW(a_copy_rem, (state_reg == ST_COPY), (rem_reg != 5'd0))
    `LZRD_ASSERT_NOW(a_fwd_dist, (state_reg == ST_COPY) && fwd_reg, (dist_reg == WIN_AW'(1)))
    `LZRD_ASSERT_NEXT(a_last_ends, (state_reg == ST_COPY) && slot_free && m_tlast_next,
        (state_reg == ST_IDLE))
    `LZRD_ASSERT_NOW(a_count_bound, m_tvalid_reg, (count_reg <= total_reg))

endmodule
